@@ rtl/nudge_peak_detector_assert.svh @@
// assertion macros shared by the nudge peak detector rtl
`ifndef NUDGE_PEAK_DETECTOR_ASSERT_SVH
`define NUDGE_PEAK_DETECTOR_ASSERT_SVH

// same-cycle implication
`define NPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nudge peak detector assertion failed");

// next-cycle implication
`define NPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nudge peak detector assertion failed");

`endif

@@ rtl/npd_pkg.sv @@
// types, codes and widths shared by the nudge peak detector
package npd_pkg;

    localparam int ACCEL_WIDTH = 16;
    localparam int CMP_W       = (ACCEL_WIDTH > 16) ? ACCEL_WIDTH : 16;
    localparam int TRIG_W      = 15;
    localparam int MS_W        = 16;
    localparam int TIME_W      = 32;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 3;

    typedef enum logic [0:0] {
        REQ_SAMPLE = 1'b0,
        REQ_EVAL   = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_PRESS   = 2'd1,
        EV_RELEASE = 2'd2
    } t_key_event;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_FWD   = 2'd1,
        DIR_LEFT  = 2'd2,
        DIR_RIGHT = 2'd3
    } t_key_dir;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TRIG = 3'd0,
        CFG_REL  = 3'd1,
        CFG_COOL = 3'd2,
        CFG_HOLD = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [TRIG_W-1:0] trig;
        logic [TRIG_W-1:0] rel;
        logic [MS_W-1:0]   cool;
        logic [MS_W-1:0]   hold;
    } t_cfg;

    typedef struct packed {
        logic [ACCEL_WIDTH-1:0] mag;
        logic                   neg;
        logic                   pos;
    } t_lane_stat;

    typedef struct packed {
        t_key_event ev;
        t_key_dir   dir;
        logic       nudging;
    } t_result;

endpackage

@@ rtl/npd_axis_lane.sv @@
// per-axis peak tracker with magnitude compare
module npd_axis_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_sample_en,
    input  logic                                i_clear,
    input  logic signed [npd_pkg::ACCEL_WIDTH-1:0] i_acc,
    output npd_pkg::t_lane_stat                 o_stat
);
    import npd_pkg::*;

    logic signed [ACCEL_WIDTH-1:0] r_peak;
    logic signed [ACCEL_WIDTH-1:0] n_peak;
    logic        [ACCEL_WIDTH-1:0] peak_mag;
    logic        [ACCEL_WIDTH-1:0] acc_mag;

    // magnitude of the most negative value wraps to its exact unsigned value
    assign peak_mag = r_peak[ACCEL_WIDTH-1] ? (~r_peak + 1'b1) : r_peak;
    assign acc_mag  = i_acc[ACCEL_WIDTH-1]  ? (~i_acc + 1'b1)  : i_acc;

    always_comb begin
        n_peak = r_peak;
        if (i_clear) begin
            n_peak = '0;
        end else if (i_sample_en && (acc_mag > peak_mag)) begin
            n_peak = i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak <= '0;
        end else begin
            r_peak <= n_peak;
        end
    end

    assign o_stat.mag = peak_mag;
    assign o_stat.neg = r_peak[ACCEL_WIDTH-1];
    assign o_stat.pos = !r_peak[ACCEL_WIDTH-1] && (r_peak != '0);

endmodule

@@ rtl/npd_merge.sv @@
// merge stage: trigger, direction and release decision over both lanes
`include "nudge_peak_detector_assert.svh"

module npd_merge (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_eval_en,
    input  logic [npd_pkg::TIME_W-1:0]         i_time_ms,
    input  npd_pkg::t_cfg                      i_cfg,
    input  npd_pkg::t_lane_stat                i_lane_x,
    input  npd_pkg::t_lane_stat                i_lane_y,
    output npd_pkg::t_result                   o_result
);
    import npd_pkg::*;

    logic              r_active;
    logic              n_active;
    t_key_dir          r_held_dir;
    t_key_dir          n_held_dir;
    logic [TIME_W-1:0] r_last_ms;
    logic [TIME_W-1:0] n_last_ms;

    logic [TIME_W-1:0] elapsed;
    logic [CMP_W-1:0]  mx;
    logic [CMP_W-1:0]  my;
    logic [CMP_W-1:0]  trig_ext;
    logic [CMP_W-1:0]  rel_ext;
    logic              above;
    logic              below;
    logic              trig_fire;
    logic              rel_fire;
    t_key_dir          new_dir;

    assign elapsed  = i_time_ms - r_last_ms;
    assign mx       = CMP_W'(i_lane_x.mag);
    assign my       = CMP_W'(i_lane_y.mag);
    assign trig_ext = CMP_W'(i_cfg.trig);
    assign rel_ext  = CMP_W'(i_cfg.rel);
    assign above    = (mx > trig_ext) || (my > trig_ext);
    assign below    = (mx < rel_ext) && (my < rel_ext);

    assign trig_fire = i_eval_en && above && !r_active
                       && (elapsed > TIME_W'(i_cfg.cool));
    assign rel_fire  = i_eval_en && !trig_fire && r_active && below
                       && (elapsed > TIME_W'(i_cfg.hold));

    // y wins ties
    always_comb begin
        if (my >= mx) begin
            new_dir = i_lane_y.pos ? DIR_FWD : DIR_NONE;
        end else begin
            new_dir = i_lane_x.neg ? DIR_LEFT : DIR_RIGHT;
        end
    end

    always_comb begin
        n_active   = r_active;
        n_held_dir = r_held_dir;
        n_last_ms  = r_last_ms;
        if (trig_fire) begin
            n_active   = 1'b1;
            n_held_dir = new_dir;
            n_last_ms  = i_time_ms;
        end else if (rel_fire) begin
            n_active   = 1'b0;
            n_held_dir = DIR_NONE;
        end
    end

    always_comb begin
        o_result.ev      = EV_NONE;
        o_result.dir     = DIR_NONE;
        o_result.nudging = n_active;
        if (trig_fire && (new_dir != DIR_NONE)) begin
            o_result.ev  = EV_PRESS;
            o_result.dir = new_dir;
        end else if (rel_fire && (r_held_dir != DIR_NONE)) begin
            o_result.ev  = EV_RELEASE;
            o_result.dir = r_held_dir;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_held_dir <= DIR_NONE;
            r_last_ms  <= '0;
        end else begin
            r_active   <= n_active;
            r_held_dir <= n_held_dir;
            r_last_ms  <= n_last_ms;
        end
    end

    `NPD_ASSERT_NEXT(a_trig_sets_state, i_clk, i_rst_n, trig_fire, r_active && (r_last_ms == $past(i_time_ms)))
    `NPD_ASSERT_NEXT(a_rel_clears_state, i_clk, i_rst_n, rel_fire, !r_active && (r_held_dir == DIR_NONE))
    `NPD_ASSERT_SAME(a_idle_no_dir, i_clk, i_rst_n, !r_active, r_held_dir == DIR_NONE)

endmodule

@@ rtl/nudge_peak_detector.sv @@
// nudge peak detector top level: config registers, two axis lanes, merge, output buffer
//
// Takes one beat per clock while o_in_ready is high: a sample beat updates the
// signed X and Y peaks, an evaluate beat decides on a key press or release and
// clears both peaks. Every input beat yields exactly one result beat; the merge
// decides combinationally from the registered lane peaks, and the result is
// written into the output buffer when the beat is accepted. A two-entry output
// buffer lets beats keep flowing while a result waits, so o_in_ready drops only
// when both entries are full. Configuration writes should be made while idle.
`include "nudge_peak_detector_assert.svh"

module nudge_peak_detector (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wen,
    input  logic [npd_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [npd_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_req_type,
    input  logic signed [npd_pkg::ACCEL_WIDTH-1:0] i_acc_x,
    input  logic signed [npd_pkg::ACCEL_WIDTH-1:0] i_acc_y,
    input  logic [npd_pkg::TIME_W-1:0]             i_time_ms,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [1:0]                             o_key_event,
    output logic [1:0]                             o_key_dir,
    output logic                                   o_nudging
);
    import npd_pkg::*;

    t_cfg       r_cfg;
    t_lane_stat lane_x;
    t_lane_stat lane_y;
    t_result    result;

    t_result    r_buf [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic [1:0] n_count;

    logic       push;
    logic       pop;
    logic       sample_en;
    logic       eval_en;

    assign o_in_ready  = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;
    assign sample_en   = push && (t_req'(i_req_type) == REQ_SAMPLE);
    assign eval_en     = push && (t_req'(i_req_type) == REQ_EVAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trig <= TRIG_W'(4000);
            r_cfg.rel  <= TRIG_W'(2000);
            r_cfg.cool <= MS_W'(500);
            r_cfg.hold <= MS_W'(100);
        end else if (i_cfg_wen) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_TRIG: r_cfg.trig <= i_cfg_wdata[TRIG_W-1:0];
                CFG_REL:  r_cfg.rel  <= i_cfg_wdata[TRIG_W-1:0];
                CFG_COOL: r_cfg.cool <= i_cfg_wdata[MS_W-1:0];
                CFG_HOLD: r_cfg.hold <= i_cfg_wdata[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    npd_axis_lane u_lane_x (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_en (sample_en),
        .i_clear     (eval_en),
        .i_acc       (i_acc_x),
        .o_stat      (lane_x)
    );

    npd_axis_lane u_lane_y (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_en (sample_en),
        .i_clear     (eval_en),
        .i_acc       (i_acc_y),
        .o_stat      (lane_y)
    );

    npd_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_eval_en (eval_en),
        .i_time_ms (i_time_ms),
        .i_cfg     (r_cfg),
        .i_lane_x  (lane_x),
        .i_lane_y  (lane_y),
        .o_result  (result)
    );

    // result buffer
    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    assign o_key_event = r_buf[r_rd_ptr].ev;
    assign o_key_dir   = r_buf[r_rd_ptr].dir;
    assign o_nudging   = r_buf[r_rd_ptr].nudging;

    `NPD_ASSERT_NEXT(a_count_grows, i_clk, i_rst_n, push && !pop, r_count == ($past(r_count) + 2'd1))
    `NPD_ASSERT_SAME(a_press_nudging, i_clk, i_rst_n, o_out_valid && (o_key_event == EV_PRESS), o_nudging && (o_key_dir != DIR_NONE))
    `NPD_ASSERT_SAME(a_release_idle, i_clk, i_rst_n, o_out_valid && (o_key_event == EV_RELEASE), !o_nudging && (o_key_dir != DIR_NONE))

endmodule

@@ dv/nudge_peak_detector_tb.sv @@
// testbench for the nudge peak detector: directed table, then random sample/evaluate bursts
`timescale 1ns / 1ps

module nudge_peak_detector_tb;
    import npd_pkg::*;

    localparam int                    PARK_CYCLES  = 40;
    localparam int unsigned           CYCLE_LIMIT  = 200000;
    localparam int                    ACC_MAX      = 2 ** (ACCEL_WIDTH - 1) - 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED = '1;
    localparam logic                  TYPED        = 1'b1;
    localparam logic                  MODEL        = 1'b0;
    localparam t_result               NO_KEY       = '{EV_NONE, DIR_NONE, 1'b0};

    typedef struct packed {
        t_req                          req;
        logic signed [ACCEL_WIDTH-1:0] ax;
        logic signed [ACCEL_WIDTH-1:0] ay;
        logic [TIME_W-1:0]             tm;
        logic                          typed;
        t_result                       want;
    } t_row;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_wen   = 1'b0;
    logic [CFG_ADDR_W-1:0]         i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_wdata = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic                          i_req_type  = 1'b0;
    logic signed [ACCEL_WIDTH-1:0] i_acc_x     = '0;
    logic signed [ACCEL_WIDTH-1:0] i_acc_y     = '0;
    logic [TIME_W-1:0]             i_time_ms   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [1:0]                    o_key_event;
    logic [1:0]                    o_key_dir;
    logic                          o_nudging;

    logic                          row_typed   = 1'b0;
    t_result                       row_want    = NO_KEY;

    // bench copy of the detector state and registers
    logic [TRIG_W-1:0]             thr_trig     = 15'd4000;
    logic [TRIG_W-1:0]             thr_rel      = 15'd2000;
    logic [MS_W-1:0]               cool_ms      = 16'd500;
    logic [MS_W-1:0]               hold_ms      = 16'd100;
    logic signed [ACCEL_WIDTH-1:0] pk_x         = '0;
    logic signed [ACCEL_WIDTH-1:0] pk_y         = '0;
    logic                          nudge_on     = 1'b0;
    t_key_dir                      held         = DIR_NONE;
    logic [TIME_W-1:0]             last_trig_ms = '0;

    t_result     key_results_due[$];
    logic [TIME_W-1:0] clock_ms;
    bit          gaps_on  = 1'b1;
    bit          park_rx  = 1'b0;
    int          n_errors = 0;
    int          n_beats  = 0;
    int          n_evals  = 0;
    int          n_press  = 0;
    int          n_rel    = 0;
    int          n_results = 0;
    int          n_settings = 1;
    int          n_parks  = 0;
    int unsigned n_cycles = 0;

    t_row plan [26] = '{
        '{REQ_EVAL,   16'sh8000,    16'sd32767,  32'd0,         TYPED, NO_KEY},
        '{REQ_SAMPLE, 16'sd0,       16'sd32767,  32'hFFFF_FFFF, TYPED, NO_KEY},
        '{REQ_SAMPLE, 16'sh8000,    -16'sd32767, 32'd0,         TYPED, NO_KEY},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'd1000,      TYPED,
          '{EV_PRESS, DIR_LEFT, 1'b1}},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'd1050,      TYPED,
          '{EV_NONE, DIR_NONE, 1'b1}},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'd1101,      TYPED,
          '{EV_RELEASE, DIR_LEFT, 1'b0}},
        '{REQ_SAMPLE, 16'sd32767,   -16'sd100,   32'd0,         MODEL, NO_KEY},
        '{REQ_SAMPLE, -16'sd5,      16'sd200,    32'd0,         MODEL, NO_KEY},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'd1400,      MODEL, NO_KEY},
        '{REQ_SAMPLE, 16'sd32767,   16'sd0,      32'd0,         MODEL, NO_KEY},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'd1501,      TYPED,
          '{EV_PRESS, DIR_RIGHT, 1'b1}},
        '{REQ_SAMPLE, 16'sd3000,    16'sd0,      32'd0,         MODEL, NO_KEY},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'd1700,      MODEL, NO_KEY},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'd1800,      TYPED,
          '{EV_RELEASE, DIR_RIGHT, 1'b0}},
        '{REQ_SAMPLE, 16'sd5000,    16'sd5000,   32'd0,         MODEL, NO_KEY},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'd2400,      TYPED,
          '{EV_PRESS, DIR_FWD, 1'b1}},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'd2600,      TYPED,
          '{EV_RELEASE, DIR_FWD, 1'b0}},
        '{REQ_SAMPLE, 16'sd100,     -16'sd5000,  32'd0,         MODEL, NO_KEY},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'd3200,      MODEL, NO_KEY},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'd3400,      MODEL, NO_KEY},
        '{REQ_SAMPLE, 16'sd0,       16'sd10000,  32'd0,         MODEL, NO_KEY},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'hFFFF_FF00, TYPED,
          '{EV_PRESS, DIR_FWD, 1'b1}},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'h0000_0010, TYPED,
          '{EV_RELEASE, DIR_FWD, 1'b0}},
        '{REQ_SAMPLE, 16'sd4000,    -16'sd4000,  32'd0,         MODEL, NO_KEY},
        '{REQ_EVAL,   16'sd0,       16'sd0,      32'h0000_1000, MODEL, NO_KEY},
        '{REQ_EVAL,   16'sd32767,   16'sh8000,   32'hFFFF_FFFF, TYPED, NO_KEY}
    };

    nudge_peak_detector DUT (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [ACCEL_WIDTH:0] accel_mag(logic signed [ACCEL_WIDTH-1:0] v);
        logic signed [ACCEL_WIDTH:0] w;
        w = v;
        return (w < 0) ? -w : w;
    endfunction

    function automatic t_result nudge_step(t_req req, logic signed [ACCEL_WIDTH-1:0] ax,
                                           logic signed [ACCEL_WIDTH-1:0] ay,
                                           logic [TIME_W-1:0] now);
        t_result           r;
        logic [TIME_W-1:0] since;
        logic [ACCEL_WIDTH:0] mx;
        logic [ACCEL_WIDTH:0] my;
        r = NO_KEY;
        if (req == REQ_SAMPLE) begin
            if (accel_mag(ax) > accel_mag(pk_x)) pk_x = ax;
            if (accel_mag(ay) > accel_mag(pk_y)) pk_y = ay;
        end else begin
            since = now - last_trig_ms;
            mx = accel_mag(pk_x);
            my = accel_mag(pk_y);
            if ((mx > thr_trig || my > thr_trig) && !nudge_on && since > cool_ms) begin
                last_trig_ms = now;
                nudge_on = 1'b1;
                if (my >= mx) begin
                    held = (pk_y > 0) ? DIR_FWD : DIR_NONE;
                end else begin
                    held = pk_x[ACCEL_WIDTH-1] ? DIR_LEFT : DIR_RIGHT;
                end
                if (held != DIR_NONE) begin
                    r.ev = EV_PRESS;
                    r.dir = held;
                end
            end else if (nudge_on && mx < thr_rel && my < thr_rel && since > hold_ms) begin
                nudge_on = 1'b0;
                if (held != DIR_NONE) begin
                    r.ev = EV_RELEASE;
                    r.dir = held;
                    held = DIR_NONE;
                end
            end
            pk_x = '0;
            pk_y = '0;
        end
        r.nudging = nudge_on;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (n_errors < 25)
            $display("%0t ns result %0d: %s got %0d, expected %0d",
                     $realtime, n_results, what, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin : mon
        t_result due;
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("timed out after %0d cycles", n_cycles);
            $display("Mismatches found");
            $finish;
        end
        if (i_cfg_wen) begin
            case (i_cfg_addr)
                CFG_TRIG: thr_trig = i_cfg_wdata[TRIG_W-1:0];
                CFG_REL:  thr_rel  = i_cfg_wdata[TRIG_W-1:0];
                CFG_COOL: cool_ms  = i_cfg_wdata[MS_W-1:0];
                CFG_HOLD: hold_ms  = i_cfg_wdata[MS_W-1:0];
                default: ;
            endcase
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            due = nudge_step(t_req'(i_req_type), i_acc_x, i_acc_y, i_time_ms);
            if (row_typed) due = row_want;
            key_results_due.push_back(due);
            n_beats++;
            if (i_req_type == REQ_EVAL) n_evals++;
            if (due.ev == EV_PRESS) n_press++;
            if (due.ev == EV_RELEASE) n_rel++;
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_results++;
            if (key_results_due.size() == 0) begin
                report_mismatch("unexpected result beat", 1, 0);
            end else begin
                due = key_results_due.pop_front();
                if (o_key_event !== due.ev) report_mismatch("key_event", o_key_event, due.ev);
                if (o_key_dir !== due.dir) report_mismatch("key_dir", o_key_dir, due.dir);
                if (o_nudging !== due.nudging)
                    report_mismatch("nudging", o_nudging, due.nudging);
            end
        end
    end

    // result side: random stalls, plus a long park on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (park_rx) begin
                park_rx = 1'b0;
                n_parks++;
                i_out_ready <= 1'b0;
                repeat (PARK_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic send_beat(input t_row b);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= b.req;
        i_acc_x    <= b.ax;
        i_acc_y    <= b.ay;
        i_time_ms  <= b.tm;
        row_typed  <= b.typed;
        row_want   <= b.want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (key_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_W-1:0] trig, input logic [CFG_DATA_W-1:0] rel,
                            input logic [CFG_DATA_W-1:0] cool, input logic [CFG_DATA_W-1:0] hold);
        cfg_write(CFG_TRIG, trig);
        cfg_write(CFG_REL, rel);
        cfg_write(CFG_COOL, cool);
        cfg_write(CFG_HOLD, hold);
        // unmapped index last so any aliasing onto a real register shows up
        cfg_write(CFG_UNMAPPED, CFG_DATA_W'($urandom));
        i_cfg_wen <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    function automatic logic signed [ACCEL_WIDTH-1:0] rand_accel();
        int m;
        int neg;
        neg = $urandom_range(0, 1);
        case ($urandom_range(0, 5))
            0: m = $urandom_range(0, thr_rel);
            1: m = thr_trig + $urandom_range(0, 2);
            2: m = $urandom_range(thr_rel, ACC_MAX);
            3: return ACCEL_WIDTH'($urandom);
            4: m = ACC_MAX + $urandom_range(0, 1);
            default: m = 0;
        endcase
        if (m > ACC_MAX + neg) m = ACC_MAX + neg;
        return ACCEL_WIDTH'(neg ? -m : m);
    endfunction

    function automatic logic [TIME_W-1:0] pick_delta();
        int unsigned span;
        span = ((cool_ms > hold_ms) ? cool_ms : hold_ms) + 2;
        case ($urandom_range(0, 7))
            0, 1: return $urandom_range(0, span);
            2: return hold_ms + $urandom_range(0, 1);
            3: return cool_ms + $urandom_range(0, 1);
            4, 5: return $urandom_range(0, 3 * span);
            6: return $urandom;
            default: return $urandom_range(0, 3);
        endcase
    endfunction

    // bursts of samples closed by an evaluate; some evaluates jump the clock
    task automatic run_random(input int n);
        t_row b;
        int   left;
        left = n;
        while (left > 0) begin
            repeat ($urandom_range(0, 6)) begin
                b = '{REQ_SAMPLE, rand_accel(), rand_accel(), TIME_W'($urandom), MODEL, NO_KEY};
                send_beat(b);
                left--;
            end
            b = '{REQ_EVAL, ACCEL_WIDTH'($urandom), ACCEL_WIDTH'($urandom), '0, MODEL, NO_KEY};
            if ($urandom_range(0, 15) == 0) begin
                b.tm = $urandom;
            end else begin
                clock_ms += pick_delta();
                b.tm = clock_ms;
            end
            send_beat(b);
            left--;
        end
    endtask

    initial begin
        clock_ms = $urandom;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < $size(plan); k++) send_beat(plan[k]);
        settle();

        set_regs(16'h8000 | 16'd4000, 16'd2000, 16'd500, 16'd100);
        run_random(250);
        settle();

        set_regs(16'd0, 16'hFFFF, 16'd0, 16'd0);
        park_rx = 1'b1;
        run_random(250);
        settle();

        set_regs(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF);
        run_random(150);
        settle();

        set_regs(CFG_DATA_W'($urandom_range(500, 12000)), CFG_DATA_W'($urandom_range(100, 3000)),
                 CFG_DATA_W'($urandom_range(0, 2000)), CFG_DATA_W'($urandom_range(0, 1000)));
        park_rx = 1'b1;
        run_random(300);
        settle();

        set_regs(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                 CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
        run_random(300);
        settle();

        gaps_on = 1'b0;
        set_regs(16'd4000, 16'd2000, 16'd500, 16'd100);
        run_random(300);
        settle();

        if (key_results_due.size() != 0)
            report_mismatch("results never delivered", key_results_due.size(), 0);
        $display("%0d beats in (%0d evaluates), %0d results out, %0d register settings",
                 n_beats, n_evals, n_results, n_settings);
        $display("%0d key presses and %0d releases predicted, output parked %0d times",
                 n_press, n_rel, n_parks);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
